// ===== rtl/core/mcpw_pkg.sv =====
// Shared types and constants of the multicolor cell pixel writer.
// Holds geometry, store address widths, pixel codes and controller/datapath links.
// No dependencies.
package mcpw_pkg;

  localparam int WidthPixels  = 160;
  localparam int HeightPixels = 192;
  localparam int CellCols     = (WidthPixels + 3) / 4;
  localparam int CellRows     = (HeightPixels + 7) / 8;
  localparam int CellCount    = CellCols * CellRows;
  localparam int BitmapBytes  = CellCount * 8;
  localparam int CellAw       = (CellCount > 1) ? $clog2(CellCount) : 1;
  localparam int BmAw         = CellAw + 3;

  localparam logic [1:0] CodeBg    = 2'd0;
  localparam logic [1:0] CodeHigh  = 2'd1;
  localparam logic [1:0] CodeLow   = 2'd2;
  localparam logic [1:0] CodeExtra = 2'd3;

  localparam logic KindWrite = 1'b0;
  localparam logic KindTest  = 1'b1;

  // One cell entry: two color slots and their used marks.
  typedef struct packed {
    logic       used_high;
    logic       used_low;
    logic [3:0] high_color;
    logic [3:0] low_color;
  } cell_t;

  typedef struct packed {
    logic clear;  // sweep one store address to zero
    logic load;   // capture a new item, read both stores
    logic exec;   // compute, write back, present result
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

endpackage

// ===== rtl/core/mcpw_ctrl.sv =====
// Controller of the multicolor cell pixel writer: reset sweep, idle, execute.
// Depends on mcpw_pkg for the command and status types.
module mcpw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mcpw_pkg::status_t status_i,
  output mcpw_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    busy_o    = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/mcpw_datapath.sv =====
// Datapath of the multicolor cell pixel writer: bitmap and cell stores,
// slot choice, bitmap merge and result registers. Depends on mcpw_pkg.
module mcpw_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcpw_pkg::cmd_t    cmd_i,
  output mcpw_pkg::status_t status_o,
  input  logic              kind_i,
  input  logic [7:0]        x_coord_i,
  input  logic [7:0]        y_coord_i,
  input  logic [3:0]        color_i,
  input  logic              cfg_valid_i,
  input  logic [3:0]        cfg_data_i,
  output logic              done_o,
  output logic [1:0]        pixel_code_o,
  output logic              out_of_range_o
);

  localparam int CellAw = mcpw_pkg::CellAw;
  localparam int BmAw   = mcpw_pkg::BmAw;

  logic [7:0]          bitmap_mem [mcpw_pkg::BitmapBytes];
  mcpw_pkg::cell_t     cell_mem   [mcpw_pkg::CellCount];

  logic [3:0]          bg_q;
  logic [BmAw-1:0]     clr_q;
  logic                done_q;
  logic [1:0]          code_q;
  logic                oor_q;

  logic                kind_q;
  logic [3:0]          col_q;
  logic [1:0]          xl_q;
  logic                inr_q;
  logic [CellAw-1:0]   cell_q;
  logic [BmAw-1:0]     byte_q;
  logic [7:0]          bm_rd_q;
  mcpw_pkg::cell_t     cell_rd_q;

  logic [CellAw-1:0]   in_cell;
  logic [BmAw-1:0]     in_byte;
  logic                in_range;

  logic [2:0]          bit_pos;
  logic [1:0]          old_code;
  logic                is_bg;
  logic [1:0]          new_code;
  mcpw_pkg::cell_t     cell_wd;
  logic [7:0]          merged;
  logic                do_write;
  logic                bm_we;
  logic                cell_we;
  logic [BmAw-1:0]     bm_wa;
  logic [CellAw-1:0]   cell_wa;
  logic [7:0]          bm_wd;
  mcpw_pkg::cell_t     cell_wdata;
  logic [1:0]          res_code;

  // Address of the incoming item.
  always_comb begin
    in_cell  = CellAw'(CellAw'(y_coord_i[7:3]) * CellAw'(mcpw_pkg::CellCols)
                       + CellAw'(x_coord_i[7:2]));
    in_byte  = {in_cell, y_coord_i[2:0]};
    in_range = ({1'b0, x_coord_i} < 9'(mcpw_pkg::WidthPixels))
            && ({1'b0, y_coord_i} < 9'(mcpw_pkg::HeightPixels));
  end

  // Capture the item and read both stores.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_i;
      col_q     <= color_i;
      xl_q      <= x_coord_i[1:0];
      inr_q     <= in_range;
      cell_q    <= in_cell;
      byte_q    <= in_byte;
      bm_rd_q   <= bitmap_mem[in_byte];
      cell_rd_q <= cell_mem[in_cell];
    end
  end

  // Slot choice and merge; leftmost pixel sits in bits 7..6.
  always_comb begin
    bit_pos  = {~xl_q, 1'b0};
    old_code = bm_rd_q[bit_pos +: 2];
    is_bg    = (col_q == bg_q);
    cell_wd  = cell_rd_q;
    priority if (is_bg) begin
      new_code = mcpw_pkg::CodeBg;
    end else if (col_q == cell_rd_q.low_color || !cell_rd_q.used_low) begin
      new_code           = mcpw_pkg::CodeLow;
      cell_wd.low_color  = col_q;
      cell_wd.used_low   = 1'b1;
    end else if (col_q == cell_rd_q.high_color || !cell_rd_q.used_high) begin
      new_code           = mcpw_pkg::CodeHigh;
      cell_wd.high_color = col_q;
      cell_wd.used_high  = 1'b1;
    end else begin
      // Extra color: its slot value is never read back, keep only the code.
      new_code = mcpw_pkg::CodeExtra;
    end
    merged = (bm_rd_q & ~(8'b11 << bit_pos)) | (8'(new_code) << bit_pos);

    do_write = cmd_i.exec && inr_q && (kind_q == mcpw_pkg::KindWrite);

    if (!inr_q) begin
      res_code = mcpw_pkg::CodeBg;
    end else if (kind_q == mcpw_pkg::KindTest) begin
      res_code = old_code;
    end else begin
      res_code = new_code;
    end

    if (cmd_i.clear) begin
      bm_we      = 1'b1;
      bm_wa      = clr_q;
      bm_wd      = '0;
      cell_we    = (clr_q[2:0] == 3'd0);
      cell_wa    = clr_q[BmAw-1:3];
      cell_wdata = '0;
    end else begin
      bm_we      = do_write;
      bm_wa      = byte_q;
      bm_wd      = merged;
      cell_we    = do_write && !is_bg;
      cell_wa    = cell_q;
      cell_wdata = cell_wd;
    end

    status_o.clear_last = (clr_q == BmAw'(mcpw_pkg::BitmapBytes - 1));
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bitmap_mem[bm_wa] <= bm_wd;
    end
    if (cell_we) begin
      cell_mem[cell_wa] <= cell_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q   <= '0;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        bg_q <= cfg_data_i;
      end
      if (cmd_i.clear && !status_o.clear_last) begin
        clr_q <= clr_q + BmAw'(1);
      end
      done_q <= cmd_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      code_q <= res_code;
      oor_q  <= !inr_q;
    end
  end

  assign done_o         = done_q;
  assign pixel_code_o   = code_q;
  assign out_of_range_o = oor_q;

endmodule

// ===== rtl/core/multicolor_cell_pixel_writer_core.sv =====
// Top level of the multicolor cell pixel writer.
// Joins mcpw_ctrl and mcpw_datapath; depends on mcpw_pkg.
//
// Usage:
//   Command channel: an access is accepted at a rising edge with start_i high
//   and busy_o low; kind_i selects write (0) or test (1) of pixel
//   (x_coord_i, y_coord_i), color_i is the color to write.
//   Result channel: done_o is high for exactly one cycle with pixel_code_o and
//   out_of_range_o; the receiver must take the beat in that cycle, it cannot stall.
//   Config channel: cfg_data_i is the background color, written at an edge with
//   cfg_valid_i and cfg_ready_o high; cfg_ready_o is always high. Write it only
//   while the block is idle.
//   Timing: both stores are read at the accepting edge, the next cycle computes
//   the code, writes back and registers the result beat. busy_o is high for
//   the cycle after acceptance, so a new access cannot be taken until that
//   execute cycle is over, set by the read-then-write of the single-port
//   bitmap and cell stores.
//   Reset: rst_ni clears control and the background color, then a sweep zeroes
//   the bitmap store one byte per cycle (cell entries along with it); busy_o
//   stays high for the whole of that sweep.
module multicolor_cell_pixel_writer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       kind_i,
  input  logic [7:0] x_coord_i,
  input  logic [7:0] y_coord_i,
  input  logic [3:0] color_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i,
  output logic       done_o,
  output logic [1:0] pixel_code_o,
  output logic       out_of_range_o
);

  mcpw_pkg::cmd_t    cmd;
  mcpw_pkg::status_t status;

  // Background register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  mcpw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  mcpw_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (kind_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .color_i        (color_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .pixel_code_o   (pixel_code_o),
    .out_of_range_o (out_of_range_o)
  );

`ifndef SYNTHESIS
  // Accepted access moves to execute, never straight to idle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && cmd.exec))
    else $error("accepted access did not enter execute");

  // Every execute cycle yields exactly one result beat, with the block idle.
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> (done_o && !busy_o))
    else $error("execute cycle gave no result beat");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd.exec))
    else $error("result beat without an execute cycle");

  // Out-of-range accesses always report the background code.
  a_oor_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (pixel_code_o == mcpw_pkg::CodeBg))
    else $error("out-of-range result with nonzero code");
`endif

endmodule

// ===== test/multicolor_cell_pixel_writer_core_test.sv =====
// Self-checking testbench for the multicolor cell pixel writer core.
// Drives write/test accesses and background writes, predicts every result beat.
// Depends on mcpw_pkg and multicolor_cell_pixel_writer_core.
module multicolor_cell_pixel_writer_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted beat before the run is declared hung. The reset
  // sweep alone keeps busy_o high for one cycle per bitmap byte.
  localparam int WatchdogCycles = 4 * mcpw_pkg::BitmapBytes;
  localparam int PhaseCount     = 8;
  localparam int PhaseItems     = 122;

  // One access plus an optional hand-typed expectation.
  typedef struct packed {
    logic       kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [3:0] color;
    logic       typed;
    logic [1:0] code;
    logic       oor;
  } access_row_t;

  typedef struct packed {
    logic [1:0] code;
    logic       oor;
  } pixel_result_t;

  // Directed accesses, background at its reset value (0). Rows with typed set
  // carry an expectation that is obvious by inspection; the rest are predicted.
  localparam int DirectedCount = 22;
  localparam access_row_t DirectedRows [DirectedCount] = '{
    // fresh bitmap reads back background everywhere
    '{mcpw_pkg::KindTest,  8'd0,   8'd0,   4'd0,  1'b1, mcpw_pkg::CodeBg, 1'b0},
    '{mcpw_pkg::KindTest,  8'd159, 8'd191, 4'd15, 1'b1, mcpw_pkg::CodeBg, 1'b0},
    // just past either edge, and the far corner of the coordinate space
    '{mcpw_pkg::KindWrite, 8'd160, 8'd0,   4'd5,  1'b1, mcpw_pkg::CodeBg, 1'b1},
    '{mcpw_pkg::KindWrite, 8'd0,   8'd192, 4'd5,  1'b1, mcpw_pkg::CodeBg, 1'b1},
    '{mcpw_pkg::KindTest,  8'd255, 8'd255, 4'd0,  1'b1, mcpw_pkg::CodeBg, 1'b1},
    '{mcpw_pkg::KindTest,  8'd160, 8'd191, 4'd0,  1'b1, mcpw_pkg::CodeBg, 1'b1},
    '{mcpw_pkg::KindWrite, 8'd255, 8'd0,   4'd15, 1'b1, mcpw_pkg::CodeBg, 1'b1},
    // background color always maps to code 0
    '{mcpw_pkg::KindWrite, 8'd0,   8'd0,   4'd0,  1'b1, mcpw_pkg::CodeBg, 1'b0},
    // fill one cell: low slot, low slot match, high slot, then the extra color
    '{mcpw_pkg::KindWrite, 8'd0,   8'd0,   4'd5,  1'b0, mcpw_pkg::CodeBg, 1'b0},
    '{mcpw_pkg::KindWrite, 8'd1,   8'd0,   4'd5,  1'b0, mcpw_pkg::CodeBg, 1'b0},
    '{mcpw_pkg::KindWrite, 8'd2,   8'd0,   4'd9,  1'b0, mcpw_pkg::CodeBg, 1'b0},
    '{mcpw_pkg::KindWrite, 8'd3,   8'd0,   4'd12, 1'b0, mcpw_pkg::CodeBg, 1'b0},
    // overwrite the extra color, then hit the high slot by match
    '{mcpw_pkg::KindWrite, 8'd0,   8'd7,   4'd13, 1'b0, mcpw_pkg::CodeBg, 1'b0},
    '{mcpw_pkg::KindWrite, 8'd1,   8'd7,   4'd9,  1'b0, mcpw_pkg::CodeBg, 1'b0},
    '{mcpw_pkg::KindTest,  8'd0,   8'd0,   4'd0,  1'b0, mcpw_pkg::CodeBg, 1'b0},
    '{mcpw_pkg::KindTest,  8'd3,   8'd0,   4'd0,  1'b0, mcpw_pkg::CodeBg, 1'b0},
    '{mcpw_pkg::KindTest,  8'd0,   8'd7,   4'd0,  1'b0, mcpw_pkg::CodeBg, 1'b0},
    // last pixel of the bitmap
    '{mcpw_pkg::KindWrite, 8'd159, 8'd191, 4'd15, 1'b0, mcpw_pkg::CodeBg, 1'b0},
    '{mcpw_pkg::KindTest,  8'd159, 8'd191, 4'd0,  1'b0, mcpw_pkg::CodeBg, 1'b0},
    // back to background over a colored pixel
    '{mcpw_pkg::KindWrite, 8'd0,   8'd0,   4'd0,  1'b1, mcpw_pkg::CodeBg, 1'b0},
    '{mcpw_pkg::KindTest,  8'd0,   8'd0,   4'd0,  1'b1, mcpw_pkg::CodeBg, 1'b0},
    '{mcpw_pkg::KindWrite, 8'd156, 8'd184, 4'd0,  1'b1, mcpw_pkg::CodeBg, 1'b0}
  };

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       start_i        = 1'b0;
  logic       busy_o;
  logic       kind_i         = mcpw_pkg::KindWrite;
  logic [7:0] x_coord_i      = '0;
  logic [7:0] y_coord_i      = '0;
  logic [3:0] color_i        = '0;
  logic       cfg_valid_i    = 1'b0;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i     = '0;
  logic       done_o;
  logic [1:0] pixel_code_o;
  logic       out_of_range_o;

  // Typed expectation travelling with the command beat.
  logic       row_typed_q = 1'b0;
  logic [1:0] row_code_q  = mcpw_pkg::CodeBg;
  logic       row_oor_q   = 1'b0;

  // Mirror of the block's stores; bit arrays start at zero like the block.
  bit   [7:0] pixel_bytes       [mcpw_pkg::BitmapBytes];
  bit   [7:0] cell_slot_colors  [mcpw_pkg::CellCount];
  bit   [2:0] cell_slot_used    [mcpw_pkg::CellCount];
  bit   [3:0] cell_extra_colors [mcpw_pkg::CellCount];
  logic [3:0] background_color = 4'd0;

  pixel_result_t expected_results [$];
  int            error_count = 0;
  int            idle_cycles = 0;

  multicolor_cell_pixel_writer_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .color_i        (color_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .pixel_code_o   (pixel_code_o),
    .out_of_range_o (out_of_range_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the code of one access and update the mirrored stores.
  function automatic void predict_pixel_code(input logic kind, input logic [7:0] x,
                                             input logic [7:0] y, input logic [3:0] color,
                                             output pixel_result_t res);
    int         cell_idx;
    int         byte_idx;
    int         shift;
    logic [7:0] slots;
    logic [2:0] used;
    res = '{code: mcpw_pkg::CodeBg, oor: 1'b1};
    if (int'(x) >= mcpw_pkg::WidthPixels || int'(y) >= mcpw_pkg::HeightPixels) begin
      return;
    end
    res.oor  = 1'b0;
    cell_idx = int'(y >> 3) * mcpw_pkg::CellCols + int'(x >> 2);
    byte_idx = cell_idx * 8 + int'(y[2:0]);
    shift    = 6 - 2 * int'(x[1:0]);
    if (kind == mcpw_pkg::KindTest) begin
      res.code = pixel_bytes[byte_idx][shift +: 2];
      return;
    end
    if (color != background_color) begin
      slots = cell_slot_colors[cell_idx];
      used  = cell_slot_used[cell_idx];
      // low slot first, then high slot, else take over the extra color
      if (color == slots[3:0] || !used[0]) begin
        res.code   = mcpw_pkg::CodeLow;
        slots[3:0] = color;
        used[0]    = 1'b1;
      end else if (color == slots[7:4] || !used[1]) begin
        res.code   = mcpw_pkg::CodeHigh;
        slots[7:4] = color;
        used[1]    = 1'b1;
      end else begin
        res.code                    = mcpw_pkg::CodeExtra;
        used[2]                     = 1'b1;
        cell_extra_colors[cell_idx] = color;
      end
      cell_slot_colors[cell_idx] = slots;
      cell_slot_used[cell_idx]   = used;
    end
    pixel_bytes[byte_idx][shift +: 2] = res.code;
  endfunction

  // Sample every handshake at the rising edge: check result beats against the
  // oldest expectation, then predict newly accepted commands.
  always @(posedge clk_i) begin
    pixel_result_t predicted;
    pixel_result_t oldest;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) background_color = cfg_data_i;
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: pixel_code=%0d out_of_range=%0b",
                 pixel_code_o, out_of_range_o);
          error_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (pixel_code_o !== oldest.code) begin
            $error("pixel_code: expected %0d, got %0d", oldest.code, pixel_code_o);
            error_count++;
          end
          if (out_of_range_o !== oldest.oor) begin
            $error("out_of_range: expected %0b, got %0b", oldest.oor, out_of_range_o);
            error_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        predict_pixel_code(kind_i, x_coord_i, y_coord_i, color_i, predicted);
        // a typed row overrides the prediction, the stores still advance
        if (row_typed_q) predicted = '{code: row_code_q, oor: row_oor_q};
        expected_results.push_back(predicted);
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogCycles) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one command beat, hold it until taken, then maybe idle a while.
  task automatic issue_access(input access_row_t row, input int idle_pct);
    int gap;
    start_i     <= 1'b1;
    kind_i      <= row.kind;
    x_coord_i   <= row.x;
    y_coord_i   <= row.y;
    color_i     <= row.color;
    row_typed_q <= row.typed;
    row_code_q  <= row.code;
    row_oor_q   <= row.oor;
    do @(posedge clk_i); while (busy_o);
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 9);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and hold off until every expected beat has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  initial begin
    access_row_t row;
    logic [3:0]  phase_backgrounds [PhaseCount];
    int          phase_idle_pct    [PhaseCount];
    int          pick;

    // Sender idle rate per phase: none, 72 in 100, none, 27 in 100, ...
    // The receiver cannot stall, so its share of each phase adds nothing.
    phase_idle_pct = '{0, 72, 0, 27, 0, 72, 27, 0};
    phase_backgrounds = '{4'd0, 4'd15, 4'($urandom_range(1, 14)), 4'd0, 4'd15,
                          4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)), 4'd0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) issue_access(DirectedRows[i], 0);

    for (int p = 0; p < PhaseCount; p++) begin
      // Reconfigure only with the block idle and nothing in flight.
      drain_results();
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= phase_backgrounds[p];
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_valid_i <= 1'b0;

      for (int n = 0; n < PhaseItems; n++) begin
        row       = '0;
        row.kind  = ($urandom_range(0, 99) < 30) ? mcpw_pkg::KindTest : mcpw_pkg::KindWrite;
        row.color = 4'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick < 10) begin
          // anywhere in the coordinate space, edges of the area included
          row.x = 8'($urandom);
          row.y = 8'($urandom);
        end else if (pick < 16) begin
          // past the right or bottom edge
          if ($urandom_range(0, 1)) begin
            row.x = 8'($urandom_range(mcpw_pkg::WidthPixels, 255));
            row.y = 8'($urandom);
          end else begin
            row.x = 8'($urandom_range(0, mcpw_pkg::WidthPixels - 1));
            row.y = 8'($urandom_range(mcpw_pkg::HeightPixels, 255));
          end
        end else begin
          // hammer a few cells in four corners so slots fill and overflow
          row.x = $urandom_range(0, 1)
                ? 8'($urandom_range(0, 7))
                : 8'($urandom_range(mcpw_pkg::WidthPixels - 8, mcpw_pkg::WidthPixels - 1));
          row.y = $urandom_range(0, 1)
                ? 8'($urandom_range(0, 15))
                : 8'($urandom_range(mcpw_pkg::HeightPixels - 16,
                                    mcpw_pkg::HeightPixels - 1));
        end
        issue_access(row, phase_idle_pct[p]);
        if ($urandom_range(0, 63) == 0) drain_results();
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d result beats never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
